[hw/rtl/group_acl_check_table_macros.svh]
// Assertion macros for the group ACL table checker.
// No dependencies.
`ifndef GROUP_ACL_CHECK_TABLE_MACROS_SVH
`define GROUP_ACL_CHECK_TABLE_MACROS_SVH
`define GACL_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (c)) else $error("gacl check failed");
`define GACL_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (c)) else $error("gacl check failed");
`endif

[hw/rtl/gacl_pkg.sv]
// Package for the group ACL table: word types and codes.
// No dependencies.
package gacl_pkg;
    localparam int GROUP_SLOTS_DEF  = 32;
    localparam int MEMBER_SLOTS_DEF = 32;
    localparam int RULE_SLOTS_DEF   = 64;
    localparam int KEY_BITS_DEF     = 64;

    localparam logic [2:0] CMD_ADD_GROUP  = 3'd0;
    localparam logic [2:0] CMD_ADD_MEMBER = 3'd1;
    localparam logic [2:0] CMD_ADD_POLICY = 3'd2;
    localparam logic [2:0] CMD_IS_MEMBER  = 3'd3;
    localparam logic [2:0] CMD_CHECK      = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOGROUP = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] group_key;
        logic [63:0] user_key;
        logic [63:0] resource_key;
        logic [31:0] group_number;
        logic [15:0] perm_mask;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       answer;
    } out_word_t;
endpackage

[hw/rtl/gacl_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module gacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hw/rtl/gacl_cell.sv]
// One slot cell of a search chain: a valid bit and a key, a match token passes down the row.
// Depends on nothing.
module gacl_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                load,
    input  logic [KEY_BITS-1:0] load_key,
    input  logic [KEY_BITS-1:0] probe,
    input  logic                hit_in,
    input  logic                free_in,
    output logic                hit_out,
    output logic                free_out,
    output logic                my_hit,
    output logic                my_free
);
    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;

    assign my_hit   = valid_reg && (key_reg == probe) && !hit_in;
    assign my_free  = !valid_reg && !free_in;
    assign hit_out  = hit_in || (valid_reg && key_reg == probe);
    assign free_out = free_in || !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= load_key;
        end
    end
endmodule

[hw/rtl/group_acl_check_table.sv]
// Group ACL table engine top level: group cell chain, rule RAM, member RAM, sequencer.
// Depends on gacl_pkg, gacl_cell, gacl_ram.
//
//  channel | dir | payload              | handshake
//  in      | in  | gacl_pkg::in_word_t  | in_valid / in_ready
//  out     | out | gacl_pkg::out_word_t | out_valid / out_ready
//
// One word at a time. Group lookup goes through the cell chain.
// Member search: each member RAM read (S_MREAD) is followed by a compare (S_MCMP);
// add member and is member search the group's members before the result.
// Check: a rule that misses goes on to the next rule, a matching rule starts a
// member search of its group; the result follows the last rule or the first member hit.
// Reset clears slot valid bits and the rule count; no clearing pass.
// A stalled result holds in the output register; the next word waits.
module group_acl_check_table #(
    parameter int GROUP_SLOTS  = gacl_pkg::GROUP_SLOTS_DEF,
    parameter int MEMBER_SLOTS = gacl_pkg::MEMBER_SLOTS_DEF,
    parameter int RULE_SLOTS   = gacl_pkg::RULE_SLOTS_DEF,
    parameter int KEY_BITS     = gacl_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gacl_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output gacl_pkg::out_word_t out_word
);
    localparam int GW  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int MW  = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
    localparam int RW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int MD  = GROUP_SLOTS * MEMBER_SLOTS;
    localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
    localparam int RLW = KEY_BITS * 2 + 16;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_MREAD, S_MCMP, S_RREAD, S_RCMP, S_RLOOK, S_DONE
    } state_t;

    state_t                   state_reg;
    gacl_pkg::in_word_t       cmd_reg;
    logic [KEY_BITS-1:0]      probe_reg;
    logic [GW-1:0]            gslot_reg;
    logic [MW:0]              midx_reg;
    logic [RW:0]              ridx_reg;
    logic [RW:0]              rcount_reg;
    logic [MW:0]              mcnt_reg [GROUP_SLOTS];
    logic [31:0]              gid_reg [GROUP_SLOTS];
    logic                     out_valid_reg;
    gacl_pkg::out_word_t      out_reg;

    logic [GROUP_SLOTS:0]     hit_c, free_c;
    logic [GROUP_SLOTS-1:0]   my_hit, my_free, load_v;
    logic                     ghit, gfree;
    logic [GW-1:0]            hit_idx, free_idx;

    logic                     m_we;
    logic [MAW-1:0]           m_addr;
    logic [KEY_BITS-1:0]      m_rdata;
    logic                     r_we;
    logic [RLW-1:0]           r_wdata, r_rdata;
    logic [RW-1:0]            r_addr;
    logic [KEY_BITS-1:0]      r_grp, r_res;
    logic [15:0]              r_perm;

    assign hit_c[0]  = 1'b0;
    assign free_c[0] = 1'b0;

    for (genvar g = 0; g < GROUP_SLOTS; g++)
    begin : g_cell
        gacl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr      (1'b0),
            .load     (load_v[g]),
            .load_key (probe_reg),
            .probe    (probe_reg),
            .hit_in   (hit_c[g]),
            .free_in  (free_c[g]),
            .hit_out  (hit_c[g+1]),
            .free_out (free_c[g+1]),
            .my_hit   (my_hit[g]),
            .my_free  (my_free[g])
        );
    end

    assign ghit  = hit_c[GROUP_SLOTS];
    assign gfree = free_c[GROUP_SLOTS];

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int g = 0; g < GROUP_SLOTS; g++)
        begin
            if (my_hit[g])
            begin
                hit_idx = GW'(g);
            end
            if (my_free[g])
            begin
                free_idx = GW'(g);
            end
        end
    end

    always_comb
    begin
        load_v = '0;
        if (state_reg == S_LOOK && cmd_reg.command == gacl_pkg::CMD_ADD_GROUP
            && !ghit && gfree)
        begin
            load_v[free_idx] = 1'b1;
        end
    end

    assign m_addr = MAW'(gslot_reg) * MAW'(MEMBER_SLOTS) + MAW'(midx_reg[MW-1:0]);
    assign m_we   = (state_reg == S_MCMP) && (midx_reg == mcnt_reg[gslot_reg])
                    && cmd_reg.command == gacl_pkg::CMD_ADD_MEMBER
                    && (midx_reg < (MW+1)'(MEMBER_SLOTS));

    gacl_ram #(.WIDTH(KEY_BITS), .DEPTH(MD)) u_mem (
        .clk   (clk),
        .we    (m_we),
        .addr  (m_addr),
        .wdata (cmd_reg.user_key[KEY_BITS-1:0]),
        .rdata (m_rdata)
    );

    assign r_we    = (state_reg == S_LOOK) && cmd_reg.command == gacl_pkg::CMD_ADD_POLICY
                     && (rcount_reg < (RW+1)'(RULE_SLOTS));
    assign r_addr  = r_we ? rcount_reg[RW-1:0] : ridx_reg[RW-1:0];
    assign r_wdata = {cmd_reg.group_key[KEY_BITS-1:0], cmd_reg.resource_key[KEY_BITS-1:0],
                      cmd_reg.perm_mask};
    assign {r_grp, r_res, r_perm} = r_rdata;

    gacl_ram #(.WIDTH(RLW), .DEPTH(RULE_SLOTS)) u_rules (
        .clk   (clk),
        .we    (r_we),
        .addr  (r_addr),
        .wdata (r_wdata),
        .rdata (r_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rcount_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg   <= in_word;
                        probe_reg <= in_word.group_key[KEY_BITS-1:0];
                        out_reg   <= '0;
                        ridx_reg  <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    gslot_reg <= hit_idx;
                    midx_reg  <= '0;
                    state_reg <= S_DONE;
                    case (cmd_reg.command)
                        gacl_pkg::CMD_ADD_GROUP:
                        begin
                            if (ghit)
                            begin
                                gid_reg[hit_idx] <= cmd_reg.group_number;
                            end
                            else if (gfree)
                            begin
                                gid_reg[free_idx]  <= cmd_reg.group_number;
                                mcnt_reg[free_idx] <= '0;
                            end
                            else
                            begin
                                out_reg.status <= gacl_pkg::ST_FULL;
                            end
                        end
                        gacl_pkg::CMD_ADD_MEMBER,
                        gacl_pkg::CMD_IS_MEMBER:
                        begin
                            if (ghit)
                            begin
                                state_reg <= S_MREAD;
                            end
                            else if (cmd_reg.command == gacl_pkg::CMD_ADD_MEMBER)
                            begin
                                out_reg.status <= gacl_pkg::ST_NOGROUP;
                            end
                        end
                        gacl_pkg::CMD_ADD_POLICY:
                        begin
                            if (r_we)
                            begin
                                rcount_reg <= rcount_reg + 1'b1;
                            end
                            else
                            begin
                                out_reg.status <= gacl_pkg::ST_FULL;
                            end
                        end
                        gacl_pkg::CMD_CHECK:
                        begin
                            state_reg <= (rcount_reg != '0) ? S_RREAD : S_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_MREAD:
                begin
                    state_reg <= S_MCMP;
                end
                S_MCMP:
                begin
                    if (midx_reg == mcnt_reg[gslot_reg])
                    begin
                        if (cmd_reg.command == gacl_pkg::CMD_ADD_MEMBER)
                        begin
                            if (m_we)
                            begin
                                mcnt_reg[gslot_reg] <= mcnt_reg[gslot_reg] + 1'b1;
                            end
                            else
                            begin
                                out_reg.status <= gacl_pkg::ST_FULL;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            midx_reg  <= (MW+1)'(MEMBER_SLOTS) + 1'b1;
                            state_reg <= (cmd_reg.command == gacl_pkg::CMD_CHECK)
                                         ? S_RCMP : S_DONE;
                        end
                    end
                    else if (m_rdata == cmd_reg.user_key[KEY_BITS-1:0])
                    begin
                        if (cmd_reg.command != gacl_pkg::CMD_ADD_MEMBER)
                        begin
                            out_reg.answer <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        midx_reg  <= midx_reg + 1'b1;
                        state_reg <= S_MREAD;
                    end
                end
                S_RREAD:
                begin
                    state_reg <= S_RLOOK;
                end
                S_RLOOK:
                begin
                    probe_reg <= r_grp;
                    if (r_res == cmd_reg.resource_key[KEY_BITS-1:0]
                        && (r_perm & cmd_reg.perm_mask) != '0)
                    begin
                        state_reg <= S_RCMP;
                        midx_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= S_RCMP;
                        midx_reg  <= (MW+1)'(MEMBER_SLOTS) + 1'b1;
                    end
                end
                S_RCMP:
                begin
                    if (midx_reg == '0)
                    begin
                        if (ghit)
                        begin
                            gslot_reg <= hit_idx;
                            state_reg <= S_MREAD;
                        end
                        else
                        begin
                            midx_reg <= (MW+1)'(MEMBER_SLOTS) + 1'b1;
                        end
                    end
                    else if (ridx_reg + 1'b1 < rcount_reg)
                    begin
                        ridx_reg  <= ridx_reg + 1'b1;
                        state_reg <= S_RREAD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[hw/rtl/gacl_checker.sv]
// Port-level checker for the group ACL table, bound to the top level.
// Depends on gacl_pkg and group_acl_check_table_macros.svh.
`include "group_acl_check_table_macros.svh"
module gacl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input gacl_pkg::out_word_t out_word
);
    `GACL_ASSERT_IMP(a_status_legal, out_valid, out_word.status != 2'd3)
    `GACL_ASSERT_IMP(a_answer_ok, out_valid && out_word.answer, out_word.status == gacl_pkg::ST_OK)
    `GACL_ASSERT_IMP(a_one_word, out_valid, !in_ready)
    `GACL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
    `GACL_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid)
endmodule

bind group_acl_check_table gacl_checker u_gacl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
